[src/scfs_pkg.sv]
// Shared types, constants and checksum helper for the command frame synchroniser.
package scfs_pkg;

    // Frame geometry
    localparam int FRAME_BYTES_DEF = 4;
    localparam int FRAME_BYTES_MIN = 2;
    localparam int FRAME_BYTES_MAX = 8;
    localparam int OUT_FIELDS      = 4;

    // Configuration port geometry: four 64-bit map words at 8-byte spacing
    localparam int MAP_WORDS = 4;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       clear_window;
    } t_req;

    typedef struct packed {
        logic [7:0] device_id;
        logic [7:0] command_code;
        logic [7:0] aux_first;
        logic [7:0] aux_second;
    } t_resp;

    // Byte add with end-around carry: a sum above 255 loses 255
    function automatic logic [7:0] f_ea_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

endpackage

[src/scfs_cell.sv]
// One window cell: holds a byte, shifts on request, extends the checksum chain.
module scfs_cell
    import scfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_sum,
    output logic [7:0] o_byte,
    output logic [7:0] o_sum
);

    logic [7:0] r_byte;

    // Take the neighbour's byte on every accepted request
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // Fold the held byte into the running checksum
    assign o_sum  = f_ea_add(i_sum, r_byte);
    assign o_byte = r_byte;

endmodule

[src/scfs_active_map.sv]
// Device activity map: APB-style register file and device id lookup.
module scfs_active_map
    import scfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic [7:0]        i_id,
    output logic              o_active
);

    logic [APB_DW-1:0] r_map [MAP_WORDS];
    logic [1:0]        w_idx;

    assign w_idx  = paddr[APB_AW-1:3];
    assign pready = 1'b1;

    // Write a map word in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAP_WORDS; k++) begin
                r_map[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_map[w_idx] <= pwdata;
        end
    end

    assign prdata   = r_map[w_idx];
    assign o_active = r_map[i_id[7:6]][i_id[5:0]];

endmodule

[src/sio_command_frame_sync.sv]
// A found frame is registered and offered at o_out_resp in the cycle after its last byte is taken.
// The input takes one byte per cycle; it stalls only while a frame waits unread in the
// output register and i_out_ready is low.
// The checksum is a ripple through FRAME_BYTES window cells, evaluated in the accept cycle.
// Reset (synchronous, i_rst_n low): window empty, map all zero, no result pending.
// No memory clearing pass: the window needs none.
module sio_command_frame_sync
    import scfs_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_req              i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_resp             o_out_resp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int WIN = FRAME_BYTES + 1;
    localparam int CW  = $clog2(WIN + 1);

    logic [CW-1:0] r_held;
    logic [CW-1:0] n_held;
    logic [CW-1:0] w_base;
    logic          w_accept;
    logic          w_full;
    logic          w_active;
    logic          w_found;
    logic [7:0]    w_byte [FRAME_BYTES];
    logic [7:0]    w_next [FRAME_BYTES];
    logic [7:0]    w_sum  [FRAME_BYTES + 1];
    logic [7:0]    w_field [OUT_FIELDS];
    logic          r_out_valid;
    t_resp         r_out;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Row of cells: oldest byte in cell 0, newest in the last cell
    assign w_sum[0] = 8'd0;
    for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
        if (k == FRAME_BYTES - 1) begin : g_tail
            assign w_next[k] = i_in_req.rx_byte;
        end else begin : g_body
            assign w_next[k] = w_byte[k + 1];
        end
        scfs_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_accept),
            .i_byte (w_next[k]),
            .i_sum  (w_sum[k]),
            .o_byte (w_byte[k]),
            .o_sum  (w_sum[k + 1])
        );
    end

    scfs_active_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_id    (w_byte[0]),
        .o_active(w_active)
    );

    // Count held bytes, restarting at the current byte on a clear request and saturating at a full window
    always_comb begin
        w_base = i_in_req.clear_window ? '0 : r_held;
        n_held = (w_base < CW'(WIN)) ? (w_base + CW'(1)) : CW'(WIN);
    end

    assign w_full  = (n_held == CW'(WIN));
    assign w_found = w_full && w_active && (w_sum[FRAME_BYTES] == i_in_req.rx_byte);

    // Fields beyond a short frame read as zero
    for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_field
        if (j < FRAME_BYTES) begin : g_used
            assign w_field[j] = w_byte[j];
        end else begin : g_zero
            assign w_field[j] = 8'd0;
        end
    end

    // Advance the window count; drop the window on a found frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (w_accept) begin
            r_held <= w_found ? '0 : n_held;
        end
    end

    // Hold the found frame until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_found) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_found) begin
            r_out.device_id    <= w_field[0];
            r_out.command_code <= w_field[1];
            r_out.aux_first    <= w_field[2];
            r_out.aux_second   <= w_field[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out;

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(WIN))
        else $error("held count beyond window depth");

    a_found_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_found |=> r_held == '0)
        else $error("window not emptied after found frame");

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_req.clear_window |=> r_held == CW'(1))
        else $error("clear request did not restart window");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_accept && w_found))
        else $error("result raised without a found frame");
`endif

endmodule
